// ===== hw/rtl/aiob_pkg.sv =====
// ----------------------------------------------------------------------------
// aiob_pkg
// Shared types and constants for the arcade I/O port bank with barrel shifter.
// ----------------------------------------------------------------------------
package aiob_pkg;

  // Command flag carried in tuser
  localparam logic CMD_READ  = 1'b0;
  localparam logic CMD_WRITE = 1'b1;

  // Port addresses
  localparam logic [7:0] PORT_INP0  = 8'h00;
  localparam logic [7:0] PORT_INP1  = 8'h01;
  localparam logic [7:0] PORT_SHAMT = 8'h02;
  localparam logic [7:0] PORT_SNDA  = 8'h03;
  localparam logic [7:0] PORT_SHIFT = 8'h04;
  localparam logic [7:0] PORT_SNDB  = 8'h05;

  // Fixed read values
  localparam logic [7:0] RD_INP0    = 8'h0f;
  localparam logic [7:0] RD_INP2    = 8'h00;
  localparam logic [7:0] RD_OPEN    = 8'hff;
  localparam logic [7:0] BTN_FORCED = 8'h08;

  localparam int unsigned QUEUE_DEPTH = 2;

  // Classified operation
  typedef enum logic [2:0] {
    OP_RD_CONST,  // read with value already resolved in the front
    OP_RD_WINDOW, // read of the shifter window
    OP_WR_SHAMT,
    OP_WR_SNDA,
    OP_WR_SHIFT,
    OP_WR_SNDB,
    OP_NOP        // write to a read-only or unused port
  } op_e;

  typedef struct packed {
    op_e        op;
    logic [7:0] arg; // write data, or the resolved read value
  } entry_t;

endpackage

// ===== hw/rtl/aiob_front.sv =====
// ----------------------------------------------------------------------------
// aiob_front
// Decodes a port access into an operation and an argument byte.
// ----------------------------------------------------------------------------
module aiob_front
  import aiob_pkg::*;
(
  input  logic       cmd_i,
  input  logic [7:0] port_number_i,
  input  logic [7:0] write_data_i,
  input  logic [6:0] button_state_i,
  output entry_t     entry_o
);

  always_comb begin
    entry_o.op  = OP_NOP;
    entry_o.arg = write_data_i;
    if (cmd_i == CMD_READ) begin
      entry_o.op = OP_RD_CONST;
      unique case (port_number_i)
        PORT_INP0:  entry_o.arg = RD_INP0;
        PORT_INP1:  entry_o.arg = {1'b0, button_state_i} | BTN_FORCED;
        PORT_SHAMT: entry_o.arg = RD_INP2;
        PORT_SNDA:  entry_o.op  = OP_RD_WINDOW;
        default:    entry_o.arg = RD_OPEN;
      endcase
    end else begin
      unique case (port_number_i)
        PORT_SHAMT: entry_o.op = OP_WR_SHAMT;
        PORT_SNDA:  entry_o.op = OP_WR_SNDA;
        PORT_SHIFT: entry_o.op = OP_WR_SHIFT;
        PORT_SNDB:  entry_o.op = OP_WR_SNDB;
        default:    entry_o.op = OP_NOP;
      endcase
    end
  end

endmodule

// ===== hw/rtl/aiob_queue.sv =====
// ----------------------------------------------------------------------------
// aiob_queue
// Two-entry FIFO between decode and execute; push and pop can happen in the same cycle.
// ----------------------------------------------------------------------------
module aiob_queue
  import aiob_pkg::*;
(
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   push_i,
  input  entry_t push_entry_i,
  output logic   full_o,
  input  logic   pop_i,
  output logic   empty_o,
  output entry_t pop_entry_o
);

  localparam int unsigned PtrW = $clog2(QUEUE_DEPTH);
  localparam int unsigned CntW = $clog2(QUEUE_DEPTH + 1);

  entry_t            mem_q [QUEUE_DEPTH];
  logic [PtrW-1:0]   wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]   rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]   count_q, count_d;
  logic              do_push, do_pop;

  assign full_o      = (count_q == CntW'(QUEUE_DEPTH));
  assign empty_o     = (count_q == '0);
  assign do_push     = push_i && !full_o;
  assign do_pop      = pop_i && !empty_o;
  assign pop_entry_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_entry_i;
    end
  end

endmodule

// ===== hw/rtl/aiob_back.sv =====
// ----------------------------------------------------------------------------
// aiob_back
// Executes queued operations: shifter, sound edge detect, output register.
// ----------------------------------------------------------------------------
module aiob_back
  import aiob_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        avail_i,
  input  entry_t      entry_i,
  output logic        pop_o,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [7:0]  read_data_o,
  output logic [8:0]  sound_start_o,
  output logic        ufo_stop_o
);

  logic [7:0]  shift_high_q, shift_high_d;
  logic [7:0]  shift_low_q, shift_low_d;
  logic [2:0]  shift_amount_q, shift_amount_d;
  logic [3:0]  snd_a_q, snd_a_d;
  logic [4:0]  snd_b_q, snd_b_d;
  logic        valid_q;
  logic [7:0]  rd_q, rd_d;
  logic [8:0]  start_q, start_d;
  logic        stop_q, stop_d;
  logic [15:0] window;

  // Output register frees up whenever it is empty or being drained
  assign pop_o  = avail_i && (!valid_q || out_ready_i);
  assign window = {shift_high_q, shift_low_q} << shift_amount_q;

  always_comb begin
    shift_high_d   = shift_high_q;
    shift_low_d    = shift_low_q;
    shift_amount_d = shift_amount_q;
    snd_a_d        = snd_a_q;
    snd_b_d        = snd_b_q;
    rd_d           = '0;
    start_d        = '0;
    stop_d         = 1'b0;
    unique case (entry_i.op)
      OP_RD_CONST:  rd_d = entry_i.arg;
      OP_RD_WINDOW: rd_d = window[15:8];
      OP_WR_SHAMT:  shift_amount_d = entry_i.arg[2:0];
      OP_WR_SNDA: begin
        snd_a_d      = entry_i.arg[3:0];
        start_d[3:0] = entry_i.arg[3:0] & ~snd_a_q;
        stop_d       = snd_a_q[0] & ~entry_i.arg[0];
      end
      OP_WR_SHIFT: begin
        shift_low_d  = shift_high_q;
        shift_high_d = entry_i.arg;
      end
      OP_WR_SNDB: begin
        snd_b_d      = entry_i.arg[4:0];
        start_d[8:4] = entry_i.arg[4:0] & ~snd_b_q;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      shift_high_q   <= '0;
      shift_low_q    <= '0;
      shift_amount_q <= '0;
      snd_a_q        <= '0;
      snd_b_q        <= '0;
      valid_q        <= 1'b0;
    end else begin
      if (pop_o) begin
        shift_high_q   <= shift_high_d;
        shift_low_q    <= shift_low_d;
        shift_amount_q <= shift_amount_d;
        snd_a_q        <= snd_a_d;
        snd_b_q        <= snd_b_d;
        valid_q        <= 1'b1;
      end else if (out_ready_i) begin
        valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      rd_q    <= rd_d;
      start_q <= start_d;
      stop_q  <= stop_d;
    end
  end

  assign out_valid_o   = valid_q;
  assign read_data_o   = rd_q;
  assign sound_start_o = start_q;
  assign ufo_stop_o    = stop_q;

endmodule

// ===== hw/rtl/arcade_io_ports_barrel_shifter.sv =====
// ----------------------------------------------------------------------------
// arcade_io_ports_barrel_shifter
// Port bank of an 8080 arcade board: input ports, 16-bit barrel shifter
// window and sound trigger edge detect, one result word per access word.
// ----------------------------------------------------------------------------
//
//  channel | dir | handshake              | contents
//  --------+-----+------------------------+----------------------------------
//  s_axis  | in  | s_axis_tvalid/tready   | one port access (read or write)
//  m_axis  | out | m_axis_tvalid/tready   | read byte and sound pulses
//
//  Throughput: one word per cycle sustained while m_axis_tready stays high;
//  the accepted word is written to a queue slot, and the back end pops it
//  into the output register once that register is empty or being drained.
//  Reset clears the shifter, shift amount, sound history and the queue.
//  The 2-entry queue absorbs output stalls; s_axis_tready drops only when
//  it is full. The output register holds its word while m_axis_tready is low.
//
module arcade_io_ports_barrel_shifter
  import aiob_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [7:0] port_number, [15:8] write_data, [22:16] button_state, [23] zero
  input  logic [23:0] s_axis_tdata,
  // [0] cmd (0 = read, 1 = write)
  input  logic        s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [7:0] read_data, [16:8] sound_start, [17] ufo_stop, [23:18] zero
  output logic [23:0] m_axis_tdata
);

  entry_t     dec_entry;
  entry_t     q_entry;
  logic       q_full;
  logic       q_empty;
  logic       q_pop;
  logic [7:0] read_data;
  logic [8:0] sound_start;
  logic       ufo_stop;

  // Front: classify the access; constant reads are resolved here
  aiob_front u_front (
    .cmd_i          (s_axis_tuser),
    .port_number_i  (s_axis_tdata[7:0]),
    .write_data_i   (s_axis_tdata[15:8]),
    .button_state_i (s_axis_tdata[22:16]),
    .entry_o        (dec_entry)
  );

  assign s_axis_tready = !q_full;

  aiob_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (s_axis_tvalid),
    .push_entry_i (dec_entry),
    .full_o       (q_full),
    .pop_i        (q_pop),
    .empty_o      (q_empty),
    .pop_entry_o  (q_entry)
  );

  // Back: state updates happen in queue order, one per pop
  aiob_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .avail_i       (!q_empty),
    .entry_i       (q_entry),
    .pop_o         (q_pop),
    .out_valid_o   (m_axis_tvalid),
    .out_ready_i   (m_axis_tready),
    .read_data_o   (read_data),
    .sound_start_o (sound_start),
    .ufo_stop_o    (ufo_stop)
  );

  assign m_axis_tdata = {6'b0, ufo_stop, sound_start, read_data};

endmodule

// ===== tb/arcade_io_ports_barrel_shifter_tb.sv =====
// ----------------------------------------------------------------------------
// arcade_io_ports_barrel_shifter_tb
// Self-checking bench for the arcade I/O port bank. A short directed table
// hits the fixed read values, the shifter window at both shift extremes and
// the sound edge detect. Random port accesses follow, weighted toward the
// live ports. Each result word is checked against a hand-written value or
// a local port model. Both stream sides idle at random in three profiles.
// ----------------------------------------------------------------------------
module arcade_io_ports_barrel_shifter_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import aiob_pkg::*;

  localparam int unsigned NUM_ROWS       = 24;
  localparam int unsigned RAND_PER_PHASE = 567;     // three phases, ~1700 words
  localparam int unsigned CYCLE_LIMIT    = 200000;  // far above the slowest run
  localparam int unsigned DRAIN_CYCLES   = 8;

  // One port access, as carried by the input word
  typedef struct packed {
    logic       cmd;
    logic [7:0] port;
    logic [7:0] data;
    logic [6:0] btn;
  } access_t;

  // One result word, split into its fields
  typedef struct packed {
    logic [7:0] rd;
    logic [8:0] start;
    logic       stop;
  } port_result_t;

  // Directed row: access plus an optional hand-written result
  typedef struct packed {
    access_t      acc;
    logic         typed;
    port_result_t res;
  } stim_row_t;

  // Rows with typed = 0 are checked against the port model instead.
  localparam stim_row_t STIM_TABLE [NUM_ROWS] = '{
    // fixed reads straight after reset
    '{'{CMD_READ,  PORT_INP0,  8'h00, 7'h00}, 1'b1, '{RD_INP0,    9'h000, 1'b0}},
    '{'{CMD_READ,  PORT_INP1,  8'hff, 7'h00}, 1'b1, '{BTN_FORCED, 9'h000, 1'b0}},
    '{'{CMD_READ,  PORT_INP1,  8'h00, 7'h7f}, 1'b1, '{8'h7f,      9'h000, 1'b0}},
    '{'{CMD_READ,  PORT_SHAMT, 8'hff, 7'h7f}, 1'b1, '{RD_INP2,    9'h000, 1'b0}},
    '{'{CMD_READ,  PORT_SNDA,  8'h00, 7'h00}, 1'b1, '{8'h00,      9'h000, 1'b0}},
    '{'{CMD_READ,  8'hff,      8'h00, 7'h55}, 1'b1, '{RD_OPEN,    9'h000, 1'b0}},
    '{'{CMD_READ,  8'h06,      8'hff, 7'h2a}, 1'b1, '{RD_OPEN,    9'h000, 1'b0}},
    // shifter: load two bytes, read window at amount 0, 7 (upper bits dropped), 4
    '{'{CMD_WRITE, PORT_SHIFT, 8'hff, 7'h00}, 1'b1, '{8'h00,      9'h000, 1'b0}},
    '{'{CMD_WRITE, PORT_SHIFT, 8'h81, 7'h00}, 1'b1, '{8'h00,      9'h000, 1'b0}},
    '{'{CMD_READ,  PORT_SNDA,  8'h00, 7'h00}, 1'b0, '0},
    '{'{CMD_WRITE, PORT_SHAMT, 8'hff, 7'h7f}, 1'b1, '{8'h00,      9'h000, 1'b0}},
    '{'{CMD_READ,  PORT_SNDA,  8'h00, 7'h00}, 1'b0, '0},
    '{'{CMD_WRITE, PORT_SHAMT, 8'h04, 7'h00}, 1'b1, '{8'h00,      9'h000, 1'b0}},
    '{'{CMD_READ,  PORT_SNDA,  8'hff, 7'h00}, 1'b0, '0},
    // sound bank A: all rising from reset, then loop bit falls with junk in the top nibble
    '{'{CMD_WRITE, PORT_SNDA,  8'h0f, 7'h00}, 1'b1, '{8'h00,      9'h00f, 1'b0}},
    '{'{CMD_WRITE, PORT_SNDA,  8'hf0, 7'h00}, 1'b1, '{8'h00,      9'h000, 1'b1}},
    '{'{CMD_WRITE, PORT_SNDA,  8'hfe, 7'h00}, 1'b0, '0},
    // sound bank B: all rising, upper bits dropped, partial re-trigger
    '{'{CMD_WRITE, PORT_SNDB,  8'hff, 7'h00}, 1'b0, '0},
    '{'{CMD_WRITE, PORT_SNDB,  8'he0, 7'h00}, 1'b0, '0},
    '{'{CMD_WRITE, PORT_SNDB,  8'h15, 7'h00}, 1'b0, '0},
    // writes to read-only or unused ports do nothing; then the shift amount goes back to 0
    '{'{CMD_WRITE, 8'hff,      8'haa, 7'h7f}, 1'b1, '{8'h00,      9'h000, 1'b0}},
    '{'{CMD_WRITE, PORT_INP0,  8'h55, 7'h00}, 1'b1, '{8'h00,      9'h000, 1'b0}},
    '{'{CMD_WRITE, PORT_INP1,  8'hff, 7'h00}, 1'b1, '{8'h00,      9'h000, 1'b0}},
    '{'{CMD_WRITE, PORT_SHAMT, 8'h00, 7'h00}, 1'b1, '{8'h00,      9'h000, 1'b0}}
  };

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [23:0] s_axis_tdata;   // [7:0] port, [15:8] write data, [22:16] buttons
  logic        s_axis_tuser;   // [0] cmd
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [23:0] m_axis_tdata;   // [7:0] read data, [16:8] sound start, [17] ufo stop

  // Local copy of the port bank state
  logic [7:0] shifter_hi;
  logic [7:0] shifter_lo;
  logic [2:0] shift_amt;
  logic [3:0] snda_prev;
  logic [4:0] sndb_prev;

  port_result_t pending_results[$];  // expected result words, oldest first
  port_result_t head_result;

  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;
  int unsigned cycle_count     = 0;
  int unsigned mismatch_count  = 0;
  int unsigned results_checked = 0;
  int unsigned pulse_results   = 0;
  int unsigned reads_sent;
  int unsigned writes_sent;

  arcade_io_ports_barrel_shifter dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // Port model: decode one access, update the state, return the result word.
  function automatic port_result_t predict_port_access(input access_t acc);
    port_result_t res;
    logic [15:0]  window;
    logic [3:0]   nv_a;
    logic [4:0]   nv_b;
    res    = '0;
    window = {shifter_hi, shifter_lo} << shift_amt;
    nv_a   = acc.data[3:0];
    nv_b   = acc.data[4:0];
    if (acc.cmd == CMD_READ) begin
      case (acc.port)
        PORT_INP0:  res.rd = RD_INP0;
        PORT_INP1:  res.rd = {1'b0, acc.btn} | BTN_FORCED;
        PORT_SHAMT: res.rd = RD_INP2;
        PORT_SNDA:  res.rd = window[15:8];   // port 3 read is the shifter window
        default:    res.rd = RD_OPEN;
      endcase
    end else begin
      case (acc.port)
        PORT_SHAMT: shift_amt = acc.data[2:0];
        PORT_SNDA: begin
          res.start[3:0] = nv_a & ~snda_prev;
          res.stop       = snda_prev[0] & ~nv_a[0];  // loop sound released
          snda_prev      = nv_a;
        end
        PORT_SHIFT: begin
          shifter_lo = shifter_hi;
          shifter_hi = acc.data;
        end
        PORT_SNDB: begin
          res.start[8:4] = nv_b & ~sndb_prev;
          sndb_prev      = nv_b;
        end
        default: ;
      endcase
    end
    return res;
  endfunction

  // Random access, weighted toward the ports that carry state
  function automatic access_t rand_access();
    access_t     acc;
    int unsigned sel;
    sel      = $urandom_range(99);
    acc.cmd  = 1'($urandom_range(1));
    acc.data = 8'($urandom_range(255));
    acc.btn  = 7'($urandom_range(127));
    if      (sel < 5)  acc.port = PORT_INP0;
    else if (sel < 15) acc.port = PORT_INP1;
    else if (sel < 30) acc.port = PORT_SHAMT;
    else if (sel < 50) acc.port = PORT_SNDA;
    else if (sel < 70) acc.port = PORT_SHIFT;
    else if (sel < 85) acc.port = PORT_SNDB;
    else               acc.port = 8'($urandom_range(255));
    return acc;
  endfunction

  // Drive one access word; entered and left at a falling edge.
  // On acceptance the model runs and the expected word is queued.
  task automatic send_access(input access_t acc, input logic typed,
                             input port_result_t typed_res);
    port_result_t pred;
    if ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
      while ($urandom_range(99) < send_idle_pct) @(negedge clk_i);
    end
    s_axis_tdata  <= {1'b0, acc.btn, acc.data, acc.port};
    s_axis_tuser  <= acc.cmd;
    s_axis_tvalid <= 1'b1;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    pred = predict_port_access(acc);
    pending_results.push_back(typed ? typed_res : pred);
    if (acc.cmd == CMD_READ) reads_sent++;
    else                     writes_sent++;
    @(negedge clk_i);
  endtask

  // Receiver backpressure, redrawn every cycle
  initial begin
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk_i);
      m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Result checker: each accepted word against the oldest expectation
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_results.size() == 0) begin
        $error("result word 0x%06h with nothing expected", m_axis_tdata);
        mismatch_count++;
      end else begin
        head_result = pending_results.pop_front();
        results_checked++;
        if (head_result.start != '0 || head_result.stop) pulse_results++;
        if (m_axis_tdata[7:0] !== head_result.rd) begin
          $error("read_data: expected 0x%02h, got 0x%02h", head_result.rd,
                 m_axis_tdata[7:0]);
          mismatch_count++;
        end
        if (m_axis_tdata[16:8] !== head_result.start) begin
          $error("sound_start: expected 0x%03h, got 0x%03h", head_result.start,
                 m_axis_tdata[16:8]);
          mismatch_count++;
        end
        if (m_axis_tdata[17] !== head_result.stop) begin
          $error("ufo_stop: expected %0d, got %0d", head_result.stop, m_axis_tdata[17]);
          mismatch_count++;
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d words outstanding", cycle_count,
               pending_results.size());
      $display("FAIL");
      $finish;
    end
  end

  initial begin
    s_axis_tvalid   = 1'b0;
    s_axis_tdata    = '0;
    s_axis_tuser    = CMD_READ;
    rst_ni          = 1'b0;
    reads_sent      = 0;
    writes_sent     = 0;
    shifter_hi      = '0;
    shifter_lo      = '0;
    shift_amt       = '0;
    snda_prev       = '0;
    sndb_prev       = '0;
    // profile 1 also covers the directed table
    send_idle_pct   = 32;
    recv_idle_pct   = 62;

    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    for (int unsigned i = 0; i < NUM_ROWS; i++) begin
      send_access(STIM_TABLE[i].acc, STIM_TABLE[i].typed, STIM_TABLE[i].res);
    end

    // three idle profiles: sender-light, receiver-light, none
    for (int unsigned phase = 0; phase < 3; phase++) begin
      case (phase)
        0:       begin send_idle_pct = 32; recv_idle_pct = 62; end
        1:       begin send_idle_pct = 62; recv_idle_pct = 32; end
        default: begin send_idle_pct = 0;  recv_idle_pct = 0;  end
      endcase
      for (int unsigned n = 0; n < RAND_PER_PHASE; n++) begin
        send_access(rand_access(), 1'b0, '0);
      end
    end
    s_axis_tvalid <= 1'b0;

    // drain, then give the output stage time to show any stray word
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("%0d access words sent (%0d reads, %0d writes) under three idle profiles",
             reads_sent + writes_sent, reads_sent, writes_sent);
    $display("%0d result words checked, %0d carrying sound pulses, %0d mismatches",
             results_checked, pulse_results, mismatch_count);
    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
